@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL of the atan2 block.
// Depends on nothing; the including module provides clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the antecedent implies the consequent in the same cycle.
`define ASSERT_IMPL(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error("implication check failed");

// Check that an expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("invariant check failed");

`endif

@@ src/atr_pkg.sv @@
// Package of the atan2 block: default widths and the constant rounding function.
// Depends on nothing.
package atr_pkg;

  localparam int CoordWidthDef    = 16;
  localparam int InnerFractionDef = 24;
  localparam int AngleWidth       = 16;

  // Round num/den to nearest with frac fraction bits (elaboration only).
  function automatic logic [63:0] atr_qconst(longint unsigned num, longint unsigned den,
                                              int frac);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = num;
    for (int i = 0; i < 4; i++) begin
      if (r >= den) begin
        r = r - den;
        q = q + 1;
      end
    end
    for (int i = 0; i < frac + 1; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    return 64'((q + 1) >> 1);
  endfunction

endpackage

@@ src/atr_div.sv @@
// Pipelined restoring divider: one quotient bit per stage, side data travels along.
// Depends on nothing; needs num_i < 2 * den_i.
module atr_div #(
  parameter int NW = 26,
  parameter int QF = 24,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [NW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QF:0]   quo_o,
  output logic [SW-1:0] side_o
);

  logic [QF:0]   vld_q;
  logic [NW-1:0] rem_q  [QF+1];
  logic [NW-1:0] den_q  [QF+1];
  logic [QF:0]   quo_q  [QF+1];
  logic [SW-1:0] side_q [QF+1];
  logic          ge0;

  // Integer bit: the quotient is below two
  assign ge0 = num_i >= den_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QF-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= ge0 ? NW'(num_i - den_i) : num_i;
    den_q[0]  <= den_i;
    quo_q[0]  <= {{QF{1'b0}}, ge0};
    side_q[0] <= side_i;
  end

  // Fraction bits: shift, compare, subtract
  for (genvar k = 1; k <= QF; k++) begin : g_stage
    logic [NW:0] sh;
    logic        ge;
    assign sh = {rem_q[k-1], 1'b0};
    assign ge = sh >= {1'b0, den_q[k-1]};
    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? NW'(sh - {1'b0, den_q[k-1]}) : sh[NW-1:0];
      den_q[k]  <= den_q[k-1];
      quo_q[k]  <= {quo_q[k-1][QF-1:0], ge};
      side_q[k] <= side_q[k-1];
    end
  end

  assign valid_o = vld_q[QF];
  assign quo_o   = quo_q[QF];
  assign side_o  = side_q[QF];

endmodule

@@ src/atan2_rational_approx.sv @@
// Top level of the atan2 block: range reduction, rational approximation, quadrant fix.
// Depends on atr_pkg, atr_div and assert_macros.svh.
//
//   channel | ports                          | handshake
//   --------+--------------------------------+----------------------------------
//   input   | coord_y_i, coord_x_i           | taken when start && !busy
//   result  | angle_o                        | one cycle, marked by done_o
//
// One item enters per cycle; busy stays low. Between input and result lie the registered
// stages and the three dividers of INNER_FRACTION+1 stages each.
// Reset clears only the valid bits; data registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
`include "assert_macros.svh"

module atan2_rational_approx #(
  parameter int COORD_WIDTH    = atr_pkg::CoordWidthDef,
  parameter int INNER_FRACTION = atr_pkg::InnerFractionDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [COORD_WIDTH-1:0]    coord_y_i,
  input  logic signed [COORD_WIDTH-1:0]    coord_x_i,
  output logic signed [atr_pkg::AngleWidth-1:0] angle_o,
  output logic                             done_o
);
  import atr_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int F   = INNER_FRACTION;
  localparam int TW  = F + 1;
  localparam int VW  = F + 2;
  localparam int MW  = 2 * VW;
  localparam int RW  = F + 4;
  localparam int Lat = 3 * F + 10;

  localparam logic [VW-1:0] One   = VW'(1) << F;
  localparam logic [VW-1:0] Pi    = VW'(atr_qconst(64'd3141592653589793, 64'd1000000000000000, F));
  localparam logic [VW-1:0] Pi2   = VW'(atr_qconst(64'd3141592653589793, 64'd2000000000000000, F));
  localparam logic [VW-1:0] Pi6   = VW'(atr_qconst(64'd3141592653589793, 64'd6000000000000000, F));
  localparam logic [VW-1:0] Tan12 = VW'(atr_qconst(64'd2679491924311227, 64'd10000000000000000, F));
  localparam logic [VW-1:0] Tan6  = VW'(atr_qconst(64'd5773502691896258, 64'd10000000000000000, F));
  localparam logic [VW-1:0] C1    = VW'(atr_qconst(64'd16867629106, 64'd10000000000, F));
  localparam logic [VW-1:0] C2    = VW'(atr_qconst(64'd4378497304, 64'd10000000000, F));
  localparam logic [VW-1:0] C3    = VW'(atr_qconst(64'd16867633134, 64'd10000000000, F));

  typedef struct packed {
    logic xz;
    logic yz;
    logic yneg;
    logic xneg;
    logic cmpl;
  } flags_t;

  typedef struct packed {
    flags_t        fl;
    logic          region;
    logic          tneg;
    logic [TW-1:0] t;
  } side_t;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Stage A: register the coordinates
  logic         a_vld_q;
  logic [W-1:0] a_y_q, a_x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    a_y_q <= coord_y_i;
    a_x_q <= coord_x_i;
  end

  // Take magnitudes and order them: smaller over larger
  logic [W-1:0] ay, ax, num1, den1;
  flags_t       a_fl;
  assign ay        = a_y_q[W-1] ? W'(-a_y_q) : a_y_q;
  assign ax        = a_x_q[W-1] ? W'(-a_x_q) : a_x_q;
  assign a_fl.xz   = a_x_q == '0;
  assign a_fl.yz   = a_y_q == '0;
  assign a_fl.yneg = a_y_q[W-1];
  assign a_fl.xneg = a_x_q[W-1];
  assign a_fl.cmpl = ay > ax;
  assign num1      = a_fl.cmpl ? ax : ay;
  assign den1      = a_fl.cmpl ? ay : ax;

  logic          d1_vld;
  logic [TW-1:0] d1_t;
  logic [$bits(flags_t)-1:0] d1_side;

  atr_div #(.NW(W), .QF(F), .SW($bits(flags_t))) u_div_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (a_vld_q),
    .num_i   (num1),
    .den_i   (den1),
    .side_i  (a_fl),
    .valid_o (d1_vld),
    .quo_o   (d1_t),
    .side_o  (d1_side)
  );

  // Stage B: product tan(pi/6) * t
  logic          b_vld_q;
  logic [TW-1:0] b_t_q;
  logic [MW-1:0] b_prod_q;
  flags_t        b_fl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= d1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    b_t_q    <= d1_t;
    b_prod_q <= MW'(d1_t) * MW'(Tan6);
    b_fl_q   <= flags_t'(d1_side);
  end

  // Shift the argument down by pi/6 through the tangent difference
  logic [VW-1:0] b_tv, den2, num2;
  side_t         b_side;
  assign b_tv          = VW'(b_t_q);
  assign den2          = One + b_prod_q[F +: VW];
  assign b_side.fl     = b_fl_q;
  assign b_side.region = b_tv > Tan12;
  assign b_side.tneg   = b_side.region && (b_tv < Tan6);
  assign b_side.t      = b_t_q;
  assign num2          = (b_tv < Tan6) ? (Tan6 - b_tv) : (b_tv - Tan6);

  logic          d2_vld;
  logic [TW-1:0] d2_q;
  logic [$bits(side_t)-1:0] d2_side_raw;
  side_t         d2_side;

  atr_div #(.NW(VW), .QF(F), .SW($bits(side_t))) u_div_shift (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (b_vld_q),
    .num_i   (num2),
    .den_i   (den2),
    .side_i  (b_side),
    .valid_o (d2_vld),
    .quo_o   (d2_q),
    .side_o  (d2_side_raw)
  );
  assign d2_side = side_t'(d2_side_raw);

  // Stage D: pick the reduced argument and square it
  logic          d_vld_q;
  side_t         d_side_q, d_side_d;
  logic [MW-1:0] d_sq_q;
  logic [TW-1:0] d_tt;
  assign d_tt = d2_side.region ? d2_q : d2_side.t;

  always_comb begin
    d_side_d   = d2_side;
    d_side_d.t = d_tt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else begin
      d_vld_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    d_side_q <= d_side_d;
    d_sq_q   <= MW'(d_tt) * MW'(d_tt);
  end

  // Stage E: s and s * C2
  logic          e_vld_q;
  side_t         e_side_q;
  logic [VW-1:0] e_s_q, d_s;
  logic [MW-1:0] e_p_q;
  assign d_s = d_sq_q[F +: VW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else begin
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e_side_q <= d_side_q;
    e_s_q    <= d_s;
    e_p_q    <= MW'(d_s) * MW'(C2);
  end

  logic [VW-1:0] num3, den3;
  assign num3 = C1 + e_p_q[F +: VW];
  assign den3 = C3 + e_s_q;

  logic          d3_vld;
  logic [TW-1:0] d3_q;
  logic [$bits(side_t)-1:0] d3_side_raw;
  side_t         d3_side;

  atr_div #(.NW(VW), .QF(F), .SW($bits(side_t))) u_div_rational (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (e_vld_q),
    .num_i   (num3),
    .den_i   (den3),
    .side_i  (e_side_q),
    .valid_o (d3_vld),
    .quo_o   (d3_q),
    .side_o  (d3_side_raw)
  );
  assign d3_side = side_t'(d3_side_raw);

  // Stage F: base angle t * ratio
  logic          f_vld_q;
  side_t         f_side_q;
  logic [MW-1:0] f_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else begin
      f_vld_q <= d3_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    f_side_q <= d3_side;
    f_r_q    <= MW'(d3_side.t) * MW'(d3_q);
  end

  // Undo the pi/6 shift and the pi/2 complement, apply the sign
  logic signed [RW-1:0] res, rbase;

  always_comb begin
    rbase = $signed({2'b00, f_r_q[F +: VW]});
    res   = f_side_q.tneg ? -rbase : rbase;
    if (f_side_q.region) begin
      res = res + $signed({2'b00, Pi6});
    end
    if (f_side_q.fl.cmpl) begin
      res = $signed({2'b00, Pi2}) - res;
    end
    if (!f_side_q.fl.yz && (f_side_q.fl.yneg != f_side_q.fl.xneg)) begin
      res = -res;
    end
  end

  // Stage G: hold the signed angle and the quadrant flags
  logic                 g_vld_q;
  flags_t               g_fl_q;
  logic signed [RW-1:0] g_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else begin
      g_vld_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    g_fl_q  <= f_side_q.fl;
    g_res_q <= res;
  end

  // Fix the quadrant, round to 13 fraction bits
  logic signed [RW-1:0]  qres;
  logic [RW-1:0]         mag, rnd, m13;
  logic                  neg;
  logic [AngleWidth-1:0] g_angle;

  always_comb begin
    qres = g_res_q;
    if (g_fl_q.xneg) begin
      qres = g_fl_q.yneg ? qres - $signed({2'b00, Pi}) : qres + $signed({2'b00, Pi});
    end
    if (g_fl_q.xz) begin
      if (g_fl_q.yz) begin
        qres = '0;
      end else if (g_fl_q.yneg) begin
        qres = -$signed({2'b00, Pi2});
      end else begin
        qres = $signed({2'b00, Pi2});
      end
    end
    neg     = qres[RW-1];
    mag     = neg ? RW'(-qres) : RW'(qres);
    rnd     = mag + (RW'(1) << (F - 14));
    m13     = rnd >> (F - 13);
    g_angle = neg ? AngleWidth'(-m13) : m13[AngleWidth-1:0];
  end

  // Stage H: result register and strobe
  logic                  done_q;
  logic [AngleWidth-1:0] angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= g_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q <= g_angle;
  end

  assign done_o  = done_q;
  assign angle_o = angle_q;

  // Checks
  `ASSERT_IMPL(a_done_from_accept, done_o, $past(accept, Lat))
  `ASSERT_IMPL(a_angle_range, done_o,
               ($signed(angle_o) <= 25736) && ($signed(angle_o) >= -25736))
  `ASSERT_IMPL(a_origin_zero,
               done_o && $past(accept && (coord_x_i == '0) && (coord_y_i == '0), Lat),
               angle_o == '0)
  `ASSERT_ALWAYS(a_never_busy, !busy)

endmodule
